/* sv/aawp_pkg.sv */
// Shared types and codes for the alarm annunciator.
package aawp_pkg;

  // Sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  // Item operations
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_LOAD   = 1'b1;

  // Sound modes held in the attribute table
  localparam logic [1:0] MODE_NONE   = 2'd0;
  localparam logic [1:0] MODE_LOOP   = 2'd1;
  localparam logic [1:0] MODE_HIGH   = 2'd2;
  localparam logic [1:0] MODE_NORMAL = 2'd3;

  // Sound requests for the addressed alarm
  localparam logic [2:0] SND_NONE   = 3'd0;
  localparam logic [2:0] SND_LOOP   = 3'd1;
  localparam logic [2:0] SND_HIGH   = 3'd2;
  localparam logic [2:0] SND_NORMAL = 3'd3;
  localparam logic [2:0] SND_STOP   = 3'd4;

  // Master warning sound requests
  localparam logic [1:0] MACT_NONE  = 2'd0;
  localparam logic [1:0] MACT_START = 2'd1;
  localparam logic [1:0] MACT_STOP  = 2'd2;

  // Ceiling of the master counter
  localparam logic [5:0] COUNT_MAX = 6'd63;

  // Input word
  typedef struct packed {
    logic        op;
    logic [4:0]  alarm_index;
    logic        condition_ok;
    logic [31:0] time_now_ms;
    logic        sound_playing;
    logic        master_sound_playing;
    logic [15:0] new_delay_ms;
    logic [15:0] new_interval_ms;
    logic        new_master_required;
    logic [1:0]  new_sound_mode;
  } sample_t;

  // Result word
  typedef struct packed {
    logic [4:0] alarm_echo;
    logic       alarm_failed;
    logic [2:0] sound_action;
    logic       master_failed;
    logic [1:0] master_action;
    logic [5:0] master_count;
  } result_t;

  // One attribute table entry
  typedef struct packed {
    logic [15:0] delay;
    logic [15:0] interval;
    logic        master_req;
    logic [1:0]  mode;
  } attr_t;

  // Write-back control for one timing entry
  typedef struct packed {
    logic we;
    logic valid;
    logic failed;
    logic mset;
  } tctl_t;

endpackage

/* sv/aawp_attr_mem.sv */
// Attribute table: one synchronous memory with a registered read port.
module aawp_attr_mem
  import aawp_pkg::*;
#(
  parameter int ALARM_COUNT = 32
) (
  input  logic                           clk,
  input  logic                           rd_en,
  input  logic [$clog2(ALARM_COUNT)-1:0] rd_addr,
  input  logic                           wr_en,
  input  logic [$clog2(ALARM_COUNT)-1:0] wr_addr,
  input  attr_t                          wr_data,
  output attr_t                          rd_data
);

  attr_t mem [ALARM_COUNT];

  // Write one entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read one entry; hold the word until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* sv/aawp_time_store.sv */
// Timing store: per-alarm timing memory plus timing valid flops.
module aawp_time_store
  import aawp_pkg::*;
#(
  parameter int ALARM_COUNT = 32,
  parameter int TIME_BITS   = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           rd_en,
  input  logic [$clog2(ALARM_COUNT)-1:0] rd_addr,
  input  logic [$clog2(ALARM_COUNT)-1:0] wr_addr,
  input  tctl_t                          wr_ctl,
  input  logic [TIME_BITS-1:0]           wr_start,
  input  logic [TIME_BITS-1:0]           wr_last,
  output logic                           rd_valid,
  output logic [TIME_BITS-1:0]           rd_start,
  output logic [TIME_BITS-1:0]           rd_last,
  output logic                           rd_failed,
  output logic                           rd_mset
);

  logic [TIME_BITS-1:0] start_mem [ALARM_COUNT];
  logic [TIME_BITS-1:0] last_mem  [ALARM_COUNT];
  logic [1:0]           flag_mem  [ALARM_COUNT];
  logic [ALARM_COUNT-1:0] valid;

  // Entry contents are meaningful only while its valid flop is set
  always_ff @(posedge clk) begin
    if (wr_ctl.we) begin
      start_mem[wr_addr] <= wr_start;
      last_mem[wr_addr]  <= wr_last;
      flag_mem[wr_addr]  <= {wr_ctl.failed, wr_ctl.mset};
    end
  end

  // Clear all timing at reset through the valid flops
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_ctl.we) begin
      valid[wr_addr] <= wr_ctl.valid;
    end
  end

  // Registered read of one entry
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_valid  <= valid[rd_addr];
      rd_start  <= start_mem[rd_addr];
      rd_last   <= last_mem[rd_addr];
      rd_failed <= flag_mem[rd_addr][1];
      rd_mset   <= flag_mem[rd_addr][0];
    end
  end

endmodule

/* sv/aawp_update.sv */
// Alarm evaluation: next timing, counter and master state for one word.
module aawp_update
  import aawp_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  sample_t              item,
  input  logic                 in_range,
  input  attr_t                attr,
  input  logic                 tv,
  input  logic [TIME_BITS-1:0] start,
  input  logic [TIME_BITS-1:0] last,
  input  logic                 flag_failed,
  input  logic                 flag_mset,
  input  logic                 failed0,
  input  logic [1:0]           mode0,
  input  logic [5:0]           count,
  output tctl_t                tw,
  output logic [TIME_BITS-1:0] start_new,
  output logic [TIME_BITS-1:0] last_new,
  output logic                 aw,
  output logic [5:0]           count_new,
  output logic                 failed0_new,
  output result_t              res
);

  logic [TIME_BITS-1:0] now;
  logic [TIME_BITS-1:0] start_v;
  logic [TIME_BITS-1:0] last_v;
  logic [TIME_BITS-1:0] el_start;
  logic [TIME_BITS-1:0] el_last;
  logic                 f_v;
  logic                 m_v;
  logic                 f_eval;
  logic                 is_zero;
  logic [2:0]           snd;
  logic [1:0]           mact;

  // An entry without running timing reads as all zero
  assign now      = TIME_BITS'(item.time_now_ms);
  assign start_v  = tv ? start : '0;
  assign last_v   = tv ? last : '0;
  assign f_v      = tv & flag_failed;
  assign m_v      = tv & flag_mset;
  assign el_start = now - start_v;
  assign el_last  = now - last_v;
  assign is_zero  = (item.alarm_index == 5'd0);

  // Evaluate the addressed alarm, then the master warning
  always_comb begin
    tw          = '{we: 1'b0, valid: tv, failed: f_v, mset: m_v};
    start_new   = start_v;
    last_new    = last_v;
    aw          = 1'b0;
    count_new   = count;
    f_eval      = failed0;
    failed0_new = failed0;
    snd         = SND_NONE;
    mact        = MACT_NONE;
    if (in_range) begin
      if (item.op == OP_LOAD) begin
        aw = 1'b1;
      end else begin
        tw.we = 1'b1;
        if (!item.condition_ok) begin
          if (!tv) begin
            tw.valid  = 1'b1;
            tw.failed = 1'b0;
            tw.mset   = 1'b0;
            start_new = now;
            last_new  = '0;
          end else if (el_start > TIME_BITS'(attr.delay)) begin
            tw.failed = 1'b1;
            f_eval    = 1'b1;
            if (attr.master_req && !m_v) begin
              tw.mset = 1'b1;
              if (count != COUNT_MAX) begin
                count_new = count + 6'd1;
              end
            end
            unique case (attr.mode)
              MODE_LOOP: begin
                if (!item.sound_playing) begin
                  snd = SND_LOOP;
                end
              end
              MODE_HIGH: begin
                snd = SND_HIGH;
              end
              MODE_NORMAL: begin
                if (el_last > TIME_BITS'(attr.interval)) begin
                  snd      = SND_NORMAL;
                  last_new = now;
                end
              end
              default: begin
              end
            endcase
          end
        end else begin
          if (tv) begin
            tw.valid  = 1'b0;
            tw.failed = 1'b0;
            tw.mset   = 1'b0;
            start_new = '0;
            last_new  = '0;
            f_eval    = 1'b0;
            if (m_v && (count != 6'd0)) begin
              count_new = count - 6'd1;
            end
          end
          if ((attr.mode == MODE_LOOP) && item.sound_playing) begin
            snd = SND_STOP;
          end
        end
        // Master warning follows the counter when entry 0 has a sound
        if (is_zero) begin
          failed0_new = f_eval;
        end
        if (mode0 != MODE_NONE) begin
          failed0_new = (count_new != 6'd0);
          if ((count_new != 6'd0) && !item.master_sound_playing) begin
            mact = MACT_START;
          end else if ((count_new == 6'd0) && item.master_sound_playing) begin
            mact = MACT_STOP;
          end
        end
      end
    end
  end

  // Build the result word
  always_comb begin
    res.alarm_echo    = item.alarm_index;
    res.alarm_failed  = in_range & (is_zero ? failed0_new : tw.failed);
    res.sound_action  = snd;
    res.master_failed = (count_new != 6'd0);
    res.master_action = mact;
    res.master_count  = count_new;
  end

endmodule

/* sv/alarm_annunciator_with_persistence.sv */
// Top level of the caution and warning annunciator with persistence.
// The accept cycle reads the addressed entry of the attribute memory and the
// timing memory (both registered synchronous reads); ST_EXEC then evaluates the
// alarm, writes the entry back and loads the result register once that is free.
// The next word can be accepted no earlier than the cycle after write-back, so a
// read never meets a pending write to the same entry. A waiting result does
// not block the next accept; only the write-back waits for the result register
// to empty. Timing entries carry one valid flop each, so reset needs no
// clearing pass; attribute entries are undefined until loaded.
module alarm_annunciator_with_persistence
  import aawp_pkg::*;
#(
  parameter int ALARM_COUNT = 32,
  parameter int TIME_BITS   = 32
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    sample_valid,
  output logic    sample_stall,
  input  sample_t sample,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  localparam int IDX_W = $clog2(ALARM_COUNT);

  state_t               state;
  state_t               state_next;
  logic                 accept;
  logic                 exec_done;
  sample_t              item;
  logic                 in_range;
  logic [IDX_W-1:0]     item_addr;
  attr_t                attr_rd;
  attr_t                attr_wr;
  logic                 tv;
  logic [TIME_BITS-1:0] t_start;
  logic [TIME_BITS-1:0] t_last;
  logic                 t_failed;
  logic                 t_mset;
  tctl_t                tw;
  tctl_t                tw_gated;
  logic [TIME_BITS-1:0] start_new;
  logic [TIME_BITS-1:0] last_new;
  logic                 aw;
  logic [5:0]           master_count;
  logic [5:0]           count_new;
  logic                 failed0;
  logic                 failed0_new;
  logic [1:0]           mode0;
  result_t              res;

  assign accept    = sample_valid && !sample_stall;
  assign item_addr = IDX_W'(item.alarm_index);

  // Sequencer: read in the accept cycle, evaluate and write back after
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    sample_stall = 1'b1;
    exec_done    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        sample_stall = 1'b0;
        if (sample_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!result_valid || !result_stall) begin
          exec_done  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Hold the accepted word
  always_ff @(posedge clk) begin
    if (accept) begin
      item     <= sample;
      in_range <= (9'(sample.alarm_index) < 9'(ALARM_COUNT));
    end
  end

  assign attr_wr = '{delay: item.new_delay_ms, interval: item.new_interval_ms,
                     master_req: item.new_master_required, mode: item.new_sound_mode};

  aawp_attr_mem #(
    .ALARM_COUNT(ALARM_COUNT)
  ) u_attr (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (IDX_W'(sample.alarm_index)),
    .wr_en   (exec_done && aw),
    .wr_addr (item_addr),
    .wr_data (attr_wr),
    .rd_data (attr_rd)
  );

  assign tw_gated = '{we: tw.we && exec_done, valid: tw.valid, failed: tw.failed,
                      mset: tw.mset};

  aawp_time_store #(
    .ALARM_COUNT(ALARM_COUNT),
    .TIME_BITS  (TIME_BITS)
  ) u_time (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (accept),
    .rd_addr   (IDX_W'(sample.alarm_index)),
    .wr_addr   (item_addr),
    .wr_ctl    (tw_gated),
    .wr_start  (start_new),
    .wr_last   (last_new),
    .rd_valid  (tv),
    .rd_start  (t_start),
    .rd_last   (t_last),
    .rd_failed (t_failed),
    .rd_mset   (t_mset)
  );

  aawp_update #(
    .TIME_BITS(TIME_BITS)
  ) u_update (
    .item        (item),
    .in_range    (in_range),
    .attr        (attr_rd),
    .tv          (tv),
    .start       (t_start),
    .last        (t_last),
    .flag_failed (t_failed),
    .flag_mset   (t_mset),
    .failed0     (failed0),
    .mode0       (mode0),
    .count       (master_count),
    .tw          (tw),
    .start_new   (start_new),
    .last_new    (last_new),
    .aw          (aw),
    .count_new   (count_new),
    .failed0_new (failed0_new),
    .res         (res)
  );

  // Master counter, master alarm failed flag and its sound mode copy
  always_ff @(posedge clk) begin
    if (rst) begin
      master_count <= '0;
      failed0      <= 1'b0;
      mode0        <= MODE_NONE;
    end else if (exec_done) begin
      master_count <= count_new;
      failed0      <= failed0_new;
      if (aw && (item.alarm_index == 5'd0)) begin
        mode0 <= item.new_sound_mode;
      end
    end
  end

  // Result register: load on write-back, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (exec_done) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_done) begin
      result <= res;
    end
  end

  // A result appears only out of the write-back cycle
  a_result_from_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == ST_EXEC))
    else $error("result raised without write-back");

  // An accepted word always moves on to the write-back state
  a_accept_to_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_EXEC))
    else $error("accepted word did not reach write-back");

  // Master counter moves only at write-back, by at most one
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (master_count != $past(master_count)) |->
      ($past(exec_done) && ((master_count == $past(master_count) + 6'd1) ||
                            (master_count == $past(master_count) - 6'd1))))
    else $error("master counter changed out of step");

  // Write-back never overwrites an unread result
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    exec_done |-> (!result_valid || !result_stall))
    else $error("result overwritten while stalled");

endmodule

/* tb/tb_alarm_annunciator_with_persistence.sv */
// Testbench for the alarm annunciator: directed table, then random phases, checked by a predictor.
`timescale 1ns / 100ps

module tb_alarm_annunciator_with_persistence;
  import aawp_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 20;
  localparam int PHASE_WORDS  = 350;
  localparam int REPORT_MAX   = 10;

  // Directed stimulus row: a typed expectation is used when typed is set
  typedef struct {
    sample_t w;
    bit      typed;
    result_t want;
  } dir_row_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    sample_valid = 1'b0;
  logic    sample_stall;
  sample_t in_word = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t out_word;

  // Predictor state
  attr_t       attr_mem [32];
  logic        timing_run [32];
  logic [31:0] fail_start [32];
  logic [31:0] last_notify [32];
  logic        alarm_down [32];
  logic        holds_master [32];
  logic [5:0]  master_cnt;
  logic [31:0] entry_loaded;
  logic [31:0] clock_ms;

  result_t  pending_results [$];
  dir_row_t directed_rows [$];
  int       mismatch_count = 0;
  int       cycle_count = 0;
  int       send_idle_pct = 0;
  int       stall_pct = 0;

  alarm_annunciator_with_persistence i_dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (in_word),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (out_word)
  );

  always #(CLK_HALF) clk = ~clk;

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Compute the result of one word and advance the predicted state
  function automatic result_t predict_annunciation(input sample_t w);
    result_t     r;
    attr_t       a;
    logic [4:0]  ix;
    logic [31:0] held_ms;
    logic [31:0] since_ms;
    r = '0;
    ix = w.alarm_index;
    r.alarm_echo = ix;
    if (w.op == OP_LOAD) begin
      attr_mem[ix].delay      = w.new_delay_ms;
      attr_mem[ix].interval   = w.new_interval_ms;
      attr_mem[ix].master_req = w.new_master_required;
      attr_mem[ix].mode       = w.new_sound_mode;
    end else begin
      a = attr_mem[ix];
      held_ms  = w.time_now_ms - fail_start[ix];
      since_ms = w.time_now_ms - last_notify[ix];
      if (!w.condition_ok) begin
        if (!timing_run[ix]) begin
          // First bad sample: start the persistence timer
          timing_run[ix] = 1'b1;
          fail_start[ix] = w.time_now_ms;
        end else if (held_ms > {16'd0, a.delay}) begin
          alarm_down[ix] = 1'b1;
          if (a.master_req && !holds_master[ix]) begin
            if (master_cnt < COUNT_MAX) master_cnt = master_cnt + 6'd1;
            holds_master[ix] = 1'b1;
          end
          case (a.mode)
            MODE_LOOP: begin
              if (!w.sound_playing) r.sound_action = SND_LOOP;
            end
            MODE_HIGH: begin
              r.sound_action = SND_HIGH;
            end
            MODE_NORMAL: begin
              if (since_ms > {16'd0, a.interval}) begin
                r.sound_action = SND_NORMAL;
                last_notify[ix] = w.time_now_ms;
              end
            end
            default: ;
          endcase
        end
      end else begin
        // Condition back: drop timing and give back any master unit
        if (timing_run[ix]) begin
          alarm_down[ix]  = 1'b0;
          timing_run[ix]  = 1'b0;
          fail_start[ix]  = '0;
          last_notify[ix] = '0;
          if (holds_master[ix]) begin
            if (master_cnt != 6'd0) master_cnt = master_cnt - 6'd1;
            holds_master[ix] = 1'b0;
          end
        end
        if (a.mode == MODE_LOOP && w.sound_playing) r.sound_action = SND_STOP;
      end
      // Master warning follows the counter
      if (attr_mem[0].mode != MODE_NONE) begin
        if (master_cnt != 6'd0) begin
          alarm_down[0] = 1'b1;
          if (!w.master_sound_playing) r.master_action = MACT_START;
        end else begin
          alarm_down[0] = 1'b0;
          if (w.master_sound_playing) r.master_action = MACT_STOP;
        end
      end
    end
    r.alarm_failed  = alarm_down[ix];
    r.master_failed = (master_cnt != 6'd0);
    r.master_count  = master_cnt;
    return r;
  endfunction

  function automatic sample_t load_word(input logic [4:0] ix, input logic [15:0] delay,
                                        input logic [15:0] interval, input logic mreq,
                                        input logic [1:0] mode);
    sample_t w;
    w = '0;
    w.op                  = OP_LOAD;
    w.alarm_index         = ix;
    w.new_delay_ms        = delay;
    w.new_interval_ms     = interval;
    w.new_master_required = mreq;
    w.new_sound_mode      = mode;
    return w;
  endfunction

  function automatic sample_t sample_word(input logic [4:0] ix, input logic ok,
                                          input logic [31:0] t, input logic play,
                                          input logic mplay);
    sample_t w;
    w = '0;
    w.op                   = OP_SAMPLE;
    w.alarm_index          = ix;
    w.condition_ok         = ok;
    w.time_now_ms          = t;
    w.sound_playing        = play;
    w.master_sound_playing = mplay;
    return w;
  endfunction

  function automatic result_t typed_result(input logic [4:0] echo, input logic failed,
                                           input logic [2:0] snd, input logic mfail,
                                           input logic [1:0] mact, input logic [5:0] cnt);
    result_t r;
    r.alarm_echo    = echo;
    r.alarm_failed  = failed;
    r.sound_action  = snd;
    r.master_failed = mfail;
    r.master_action = mact;
    r.master_count  = cnt;
    return r;
  endfunction

  // Mostly short spans so alarms trip, now and then a full-range one
  function automatic logic [15:0] pick_span();
    if ($urandom_range(0, 9) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 12));
  endfunction

  // Present one word, idling first at random, and hold it until accepted
  task automatic offer_word(input sample_t w);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    in_word      <= w;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
  endtask

  // Hold the sender until every expected result is back
  task automatic wait_drained();
    sample_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Random words: mostly samples on a few alarms with time creeping forward
  task automatic run_phase(input int n, input int send_pct, input int recv_pct);
    sample_t    w;
    logic [4:0] ix;
    send_idle_pct = send_pct;
    stall_pct     = recv_pct;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 3) == 0) ix = 5'($urandom_range(0, 31));
      else ix = 5'($urandom_range(0, 7));
      if (!entry_loaded[ix] || $urandom_range(0, 99) < 6) begin
        w = load_word(ix, pick_span(), pick_span(), 1'($urandom_range(0, 1)),
                      2'($urandom_range(0, 3)));
        entry_loaded[ix] = 1'b1;
      end else begin
        if ($urandom_range(0, 49) == 0) clock_ms = $urandom;
        else clock_ms = clock_ms + 32'($urandom_range(0, 5));
        w = sample_word(ix, ($urandom_range(0, 99) < 25), clock_ms,
                        1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        // Load fields are noise on a sample
        w.new_delay_ms        = 16'($urandom);
        w.new_interval_ms     = 16'($urandom);
        w.new_master_required = 1'($urandom_range(0, 1));
        w.new_sound_mode      = 2'($urandom_range(0, 3));
      end
      pending_results.push_back(predict_annunciation(w));
      offer_word(w);
    end
    wait_drained();
  endtask

  // Receive results and compare with the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("unexpected result word: echo=%0d failed=%0b snd=%0d mfail=%0b mact=%0d cnt=%0d",
                   out_word.alarm_echo, out_word.alarm_failed, out_word.sound_action,
                   out_word.master_failed, out_word.master_action, out_word.master_count);
      end else begin
        want = pending_results.pop_front();
        if (out_word.alarm_echo !== want.alarm_echo ||
            out_word.alarm_failed !== want.alarm_failed ||
            out_word.sound_action !== want.sound_action ||
            out_word.master_failed !== want.master_failed ||
            out_word.master_action !== want.master_action ||
            out_word.master_count !== want.master_count) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("result mismatch: want echo=%0d failed=%0b snd=%0d mfail=%0b mact=%0d cnt=%0d, got echo=%0d failed=%0b snd=%0d mfail=%0b mact=%0d cnt=%0d",
                     want.alarm_echo, want.alarm_failed, want.sound_action,
                     want.master_failed, want.master_action, want.master_count,
                     out_word.alarm_echo, out_word.alarm_failed, out_word.sound_action,
                     out_word.master_failed, out_word.master_action, out_word.master_count);
        end
      end
    end
    result_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  initial begin
    result_t got;
    for (int i = 0; i < 32; i++) begin
      attr_mem[i]     = '0;
      timing_run[i]   = 1'b0;
      fail_start[i]   = '0;
      last_notify[i]  = '0;
      alarm_down[i]   = 1'b0;
      holds_master[i] = 1'b0;
    end
    master_cnt   = '0;
    entry_loaded = '0;

    // Loads at the field extremes, then persistence, wrap and sound cases
    directed_rows.push_back('{load_word(5'd0, 16'd0, 16'd0, 1'b0, MODE_LOOP), 1'b1,
                              typed_result(5'd0, 1'b0, SND_NONE, 1'b0, MACT_NONE, 6'd0)});
    directed_rows.push_back('{load_word(5'd1, 16'hFFFF, 16'hFFFF, 1'b1, MODE_HIGH), 1'b1,
                              typed_result(5'd1, 1'b0, SND_NONE, 1'b0, MACT_NONE, 6'd0)});
    directed_rows.push_back('{load_word(5'd31, 16'd0, 16'd0, 1'b1, MODE_NORMAL), 1'b1,
                              typed_result(5'd31, 1'b0, SND_NONE, 1'b0, MACT_NONE, 6'd0)});
    directed_rows.push_back('{load_word(5'd2, 16'd5, 16'd10, 1'b0, MODE_LOOP), 1'b1,
                              typed_result(5'd2, 1'b0, SND_NONE, 1'b0, MACT_NONE, 6'd0)});
    // First bad sample only starts the timer; master sound is stopped
    directed_rows.push_back('{sample_word(5'd31, 1'b0, 32'hFFFF_FFFE, 1'b0, 1'b1), 1'b1,
                              typed_result(5'd31, 1'b0, SND_NONE, 1'b0, MACT_STOP, 6'd0)});
    // Time wraps past zero
    directed_rows.push_back('{sample_word(5'd31, 1'b0, 32'd1, 1'b0, 1'b0), 1'b0, '0});
    directed_rows.push_back('{sample_word(5'd31, 1'b0, 32'd1, 1'b1, 1'b1), 1'b0, '0});
    // Delay exactly reached does not fail, one past does
    directed_rows.push_back('{sample_word(5'd1, 1'b0, 32'd0, 1'b0, 1'b0), 1'b0, '0});
    directed_rows.push_back('{sample_word(5'd1, 1'b0, 32'h0000_FFFF, 1'b0, 1'b0), 1'b0, '0});
    directed_rows.push_back('{sample_word(5'd1, 1'b0, 32'h0001_0000, 1'b1, 1'b1), 1'b0, '0});
    // Master entry sampled directly
    directed_rows.push_back('{sample_word(5'd0, 1'b1, 32'd7, 1'b1, 1'b0), 1'b0, '0});
    // Looping alarm: no start while playing, start when silent
    directed_rows.push_back('{sample_word(5'd2, 1'b0, 32'd100, 1'b1, 1'b0), 1'b0, '0});
    directed_rows.push_back('{sample_word(5'd2, 1'b0, 32'd106, 1'b1, 1'b0), 1'b0, '0});
    directed_rows.push_back('{sample_word(5'd2, 1'b0, 32'd106, 1'b0, 1'b1), 1'b0, '0});
    // Master flag cleared while a unit is held; the unit still comes back
    directed_rows.push_back('{load_word(5'd31, 16'd0, 16'd0, 1'b0, MODE_NORMAL), 1'b0, '0});
    directed_rows.push_back('{sample_word(5'd31, 1'b1, 32'd2, 1'b0, 1'b1), 1'b0, '0});
    directed_rows.push_back('{sample_word(5'd1, 1'b1, 32'h0001_0001, 1'b1, 1'b1), 1'b0, '0});
    // Clear of a looping alarm that is playing stops it
    directed_rows.push_back('{sample_word(5'd2, 1'b1, 32'd110, 1'b1, 1'b0), 1'b0, '0});
    // Master entry with no sound: no master update at all
    directed_rows.push_back('{load_word(5'd0, 16'hFFFF, 16'hFFFF, 1'b1, MODE_NONE), 1'b0, '0});
    directed_rows.push_back('{sample_word(5'd2, 1'b0, 32'd0, 1'b0, 1'b1), 1'b0, '0});
    directed_rows.push_back('{load_word(5'd0, 16'hFFFF, 16'd0, 1'b1, MODE_HIGH), 1'b0, '0});
    directed_rows.push_back('{sample_word(5'd0, 1'b0, 32'hFFFF_FFFF, 1'b1, 1'b1), 1'b0, '0});

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table without idling
    foreach (directed_rows[i]) begin
      got = predict_annunciation(directed_rows[i].w);
      if (directed_rows[i].w.op == OP_LOAD)
        entry_loaded[directed_rows[i].w.alarm_index] = 1'b1;
      pending_results.push_back(directed_rows[i].typed ? directed_rows[i].want : got);
      offer_word(directed_rows[i].w);
    end
    wait_drained();

    clock_ms = $urandom;
    run_phase(PHASE_WORDS, 22, 51);
    run_phase(PHASE_WORDS, 51, 22);
    run_phase(PHASE_WORDS, 0, 0);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/aawp_pkg.sv
sv/aawp_attr_mem.sv
sv/aawp_time_store.sv
sv/aawp_update.sv
sv/alarm_annunciator_with_persistence.sv
tb/tb_alarm_annunciator_with_persistence.sv
